[sv/pte_pkg.sv]
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types, constants and helpers of the pixel to ANSI truecolor encoder.
// ----------------------------------------------------------------------------
package pte_pkg;

   localparam int DIM_BITS_DEF       = 12;
   localparam int CSR_INDEX_W        = 4;
   localparam int RESET_FRAME_WIDTH  = 80;
   localparam int RESET_FRAME_HEIGHT = 24;
   localparam int QUEUE_DEPTH        = 2;   // power of two

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   // stream characters
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_HOME     = 8'h48;   // 'H'
   localparam logic [7:0] CH_SEMI     = 8'h3b;
   localparam logic [7:0] CH_SGR_END  = 8'h6d;   // 'm'
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NEWLINE  = 8'h0a;
   localparam logic [7:0] CH_ZERO     = 8'h30;

   // ESC [ 4 8 ; 2 ; packed low byte first
   localparam logic [55:0] BG_PREFIX_SEQ = 56'h3b323b38345b1b;
   // ESC [ 0 m packed low byte first
   localparam logic [31:0] SGR_RESET_SEQ = 32'h6d305b1b;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] glyph_code;
   } pixel_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_pixel;
      logic       frame_done;
   } term_byte_type;

   // unpadded decimal: cnt digits, dig[2] is hundreds
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][3:0] dig;
   } decimal_type;

   // one classified pixel, handed from front to back
   typedef struct packed {
      logic        home;
      logic        color_chg;
      decimal_type red_dec;
      decimal_type green_dec;
      decimal_type blue_dec;
      logic [7:0]  glyph;
      logic        newline;
      logic        frame_end;
   } cmd_type;

   // 8-bit value to decimal digits; tens by reciprocal multiply (205 / 2048)
   function automatic decimal_type to_decimal(input logic [7:0] v);
      logic [1:0]  h;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  t;
      logic [6:0]  tx10;
      decimal_type d;
      h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
      rem = 7'(v - 8'(8'(h) * 8'd100));
      prod = 15'(rem) * 15'd205;
      t = 4'(prod >> 11);
      tx10 = 7'(t) * 7'd10;
      d.dig[2] = 4'(h);
      d.dig[1] = t;
      d.dig[0] = 4'(rem - tx10);
      if (v >= 8'd100) begin
         d.cnt = 2'd3;
      end else if (v >= 8'd10) begin
         d.cnt = 2'd2;
      end else if (v != 8'd0) begin
         d.cnt = 2'd1;
      end else begin
         d.cnt = 2'd0;
      end
      return d;
   endfunction

endpackage

[sv/pte_front.sv]
// ----------------------------------------------------------------------------
// pte_front
// Accepts pixels, tracks row/column/color state and classifies each pixel.
// ----------------------------------------------------------------------------
module pte_front #(
   parameter int DIM_BITS = pte_pkg::DIM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pte_pkg::pixel_type              req_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_BITS-1:0]             csr_wdata,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output pte_pkg::cmd_type                cmd
);

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [23:0]         prev_color_ff, prev_color_in;

   logic [23:0]         color;
   logic [DIM_BITS:0]   col_p1, row_p1;
   logic                home, chg, row_end, frame_end, accept;

   assign csr_ready = 1'b1;
   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   assign color     = {req_pixel.red, req_pixel.green, req_pixel.blue};
   assign home      = (col_ff == '0) && (row_ff == '0);
   // frame start forgets the old color
   assign chg       = home ? (color != 24'd0) : (color != prev_color_ff);
   assign col_p1    = {1'b0, col_ff} + (DIM_BITS+1)'(1);
   assign row_p1    = {1'b0, row_ff} + (DIM_BITS+1)'(1);
   assign row_end   = col_p1 >= {1'b0, width_ff};
   assign frame_end = row_end && (row_p1 >= {1'b0, height_ff});

   always_comb begin
      cmd.home      = home;
      cmd.color_chg = chg;
      cmd.red_dec   = pte_pkg::to_decimal(req_pixel.red);
      cmd.green_dec = pte_pkg::to_decimal(req_pixel.green);
      cmd.blue_dec  = pte_pkg::to_decimal(req_pixel.blue);
      cmd.glyph     = (req_pixel.glyph_code == 8'd0) ? pte_pkg::CH_SPACE
                                                     : req_pixel.glyph_code;
      cmd.newline   = row_end;
      cmd.frame_end = frame_end;
   end

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      prev_color_in = prev_color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pte_pkg::REG_FRAME_WIDTH:  width_in  = csr_wdata;
            pte_pkg::REG_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      if (accept) begin
         prev_color_in = color;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_p1[DIM_BITS-1:0];
         end else begin
            col_in = col_p1[DIM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_BITS'(pte_pkg::RESET_FRAME_WIDTH);
         height_ff     <= DIM_BITS'(pte_pkg::RESET_FRAME_HEIGHT);
         col_ff        <= '0;
         row_ff        <= '0;
         prev_color_ff <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         prev_color_ff <= prev_color_in;
      end
   end

endmodule

[sv/pte_queue.sv]
// ----------------------------------------------------------------------------
// pte_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module pte_queue #(
   parameter int DEPTH = pte_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pte_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output pte_pkg::cmd_type pop_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pte_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != (AW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/pte_back.sv]
// ----------------------------------------------------------------------------
// pte_back
// Walks the byte segments of the queue head and fills the output register.
// ----------------------------------------------------------------------------
module pte_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  pte_pkg::cmd_type       cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pte_pkg::term_byte_type rsp_item
);

   typedef enum logic [10:0] {
      SEG_HOME   = 11'b000_0000_0001,
      SEG_PREFIX = 11'b000_0000_0010,
      SEG_RED    = 11'b000_0000_0100,
      SEG_SEMI1  = 11'b000_0000_1000,
      SEG_GREEN  = 11'b000_0001_0000,
      SEG_SEMI2  = 11'b000_0010_0000,
      SEG_BLUE   = 11'b000_0100_0000,
      SEG_EMM    = 11'b000_1000_0000,
      SEG_GLYPH  = 11'b001_0000_0000,
      SEG_NL     = 11'b010_0000_0000,
      SEG_RESET  = 11'b100_0000_0000
   } seg_type;

   seg_type                seg_ff, seg_in, cur_seg;
   logic [2:0]             idx_ff, idx_in, cur_idx, seg_len;
   logic                   active_ff, active_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pte_pkg::term_byte_type rsp_item_ff, rsp_item_in;

   logic [10:0]            present, first_vec, above, next_vec;
   logic                   fire, seg_done, last;
   pte_pkg::decimal_type   cur_dec;
   logic [1:0]             dig_pos;
   logic [7:0]             cur_byte;

   // segments this pixel needs, in stream order
   assign present = {cmd.frame_end, cmd.newline, 1'b1,
                     cmd.color_chg,
                     cmd.color_chg && (cmd.blue_dec.cnt != 2'd0),
                     cmd.color_chg,
                     cmd.color_chg && (cmd.green_dec.cnt != 2'd0),
                     cmd.color_chg,
                     cmd.color_chg && (cmd.red_dec.cnt != 2'd0),
                     cmd.color_chg, cmd.home};
   assign first_vec = present & (~present + 11'd1);
   assign cur_seg   = active_ff ? seg_ff : seg_type'(first_vec);
   assign cur_idx   = active_ff ? idx_ff : 3'd0;
   assign above     = present & ~((11'(cur_seg) << 1) - 11'd1);
   assign next_vec  = above & (~above + 11'd1);

   always_comb begin
      cur_dec = cmd.red_dec;
      case (cur_seg)
         SEG_GREEN: cur_dec = cmd.green_dec;
         SEG_BLUE:  cur_dec = cmd.blue_dec;
         default:   cur_dec = cmd.red_dec;
      endcase
   end

   // most significant digit first
   assign dig_pos = cur_dec.cnt - 2'd1 - cur_idx[1:0];

   always_comb begin
      seg_len  = 3'd1;
      cur_byte = cmd.glyph;
      case (cur_seg)
         SEG_HOME: begin
            seg_len  = 3'd3;
            cur_byte = (cur_idx == 3'd0) ? pte_pkg::CH_ESC :
                       (cur_idx == 3'd1) ? pte_pkg::CH_LBRACKET : pte_pkg::CH_HOME;
         end
         SEG_PREFIX: begin
            seg_len  = 3'd7;
            cur_byte = pte_pkg::BG_PREFIX_SEQ[{cur_idx, 3'b000} +: 8];
         end
         SEG_RED, SEG_GREEN, SEG_BLUE: begin
            seg_len  = {1'b0, cur_dec.cnt};
            cur_byte = pte_pkg::CH_ZERO + {4'd0, cur_dec.dig[dig_pos]};
         end
         SEG_SEMI1, SEG_SEMI2: cur_byte = pte_pkg::CH_SEMI;
         SEG_EMM:              cur_byte = pte_pkg::CH_SGR_END;
         SEG_GLYPH:            cur_byte = cmd.glyph;
         SEG_NL:               cur_byte = pte_pkg::CH_NEWLINE;
         SEG_RESET: begin
            seg_len  = 3'd4;
            cur_byte = pte_pkg::SGR_RESET_SEQ[{cur_idx[1:0], 3'b000} +: 8];
         end
         default: ;
      endcase
   end

   assign seg_done  = (cur_idx + 3'd1) == seg_len;
   assign last      = seg_done && (above == '0);
   assign fire      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = fire && last;

   always_comb begin
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in               = 1'b1;
         rsp_item_in.out_byte       = cur_byte;
         rsp_item_in.last_of_pixel  = last;
         rsp_item_in.frame_done     = last && cmd.frame_end;
         if (last) begin
            active_in = 1'b0;
         end else if (seg_done) begin
            active_in = 1'b1;
            seg_in    = seg_type'(next_vec);
            idx_in    = 3'd0;
         end else begin
            active_in = 1'b1;
            seg_in    = cur_seg;
            idx_in    = cur_idx + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         seg_ff       <= SEG_HOME;
         idx_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[sv/pixel_to_ansi_truecolor_encoder_core.sv]
// ----------------------------------------------------------------------------
// pixel_to_ansi_truecolor_encoder_core
// Turns raster-order pixels into an ANSI 24-bit background color byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* takes one pixel item (red, green, blue, glyph_code) per handshake.
//  - rsp_* gives one stream byte per handshake; last_of_pixel marks the final
//    byte of a pixel, frame_done the final byte of ESC [ 0 m at frame end.
//  - csr_* writes frame_width (index 0) or frame_height (index 1); other
//    indexes are dropped. csr_ready is always high. Write only while idle.
//  - A pixel costs 1 to 28 output bytes; while rsp_ready is high, one byte
//    leaves per cycle from the back-end emitter. A pixel with a new color is
//    typically about 17 bytes, an unchanged color just the glyph byte (plus
//    home at frame start, newline/reset at ends). A taken pixel is written
//    into the queue; its first byte is then registered in the output
//    register when the back end is free. A 2-entry queue lets the front keep
//    taking pixels while the back end is still emitting or rsp_ready is low.
//  - Reset: width 80, height 24, position at frame start, color black.
//  - When rsp_ready is low the output byte holds and the emitter waits;
//    req_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module pixel_to_ansi_truecolor_encoder_core #(
   parameter int DIM_BITS = pte_pkg::DIM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pte_pkg::pixel_type              req_pixel,
   // byte output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pte_pkg::term_byte_type          rsp_item,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_BITS-1:0]             csr_wdata
);

   // front -> queue
   logic             fq_valid, fq_ready;
   pte_pkg::cmd_type fq_cmd;
   // queue -> back
   logic             qb_valid, qb_ready;
   pte_pkg::cmd_type qb_cmd;

   // front: counters, color memory, classification
   pte_front #(
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   pte_queue #(
      .DEPTH (pte_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // back: byte sequencer plus output register
   pte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // pixels taken whose last byte is not yet delivered:
   // at most queue depth plus one in the output register
   logic [2:0] pend_ff, pend_in;
   logic       req_fire, pix_done;

   assign req_fire = req_valid && req_ready;
   assign pix_done = rsp_valid && rsp_ready && rsp_item.last_of_pixel;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !pix_done) begin
         pend_in = pend_ff + 3'd1;
      end else if (pix_done && !req_fire) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'(pte_pkg::QUEUE_DEPTH + 1))
      else $error("more pixels in flight than the queue and output can hold");

   a_no_orphan_byte: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 3'd0) |-> !rsp_valid)
      else $error("byte offered with no pixel in flight");

   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.frame_done) |-> rsp_item.last_of_pixel)
      else $error("frame_done on a byte that does not end its pixel");

   a_stall_no_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !qb_ready)
      else $error("queue popped while output stalled");

endmodule
